// ===== rtl/vna_pkg.sv =====
package vna_pkg;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 24;
  localparam int EDGE_W  = 25;
  localparam int NRM_W   = 16;
  localparam int ACC_W   = 56;
  localparam int THR_W   = 64;
  localparam int MUL_W   = 33;
  localparam int PADDR_W = 4;

  typedef logic [1:0]              mode_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  localparam mode_t MODE_LOAD = 2'd0;
  localparam mode_t MODE_TRI  = 2'd1;
  localparam mode_t MODE_READ = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0] THR_RESET = 64'd281;
  localparam logic [NRM_W-1:0] ONE_Q14   = 16'd16384;
  localparam logic [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== rtl/vna_in_if.sv =====
interface vna_in_if;
  logic           valid;
  logic           ready;
  vna_pkg::mode_t mode;
  vna_pkg::idx_t  vertex_a;
  vna_pkg::idx_t  vertex_b;
  vna_pkg::idx_t  vertex_c;
  vna_pkg::pos_t  pos_x;
  vna_pkg::pos_t  pos_y;
  vna_pkg::pos_t  pos_z;

  modport source (output valid, mode, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, mode, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

// ===== rtl/vna_out_if.sv =====
interface vna_out_if;
  logic          valid;
  logic          ready;
  vna_pkg::idx_t vertex_index;
  vna_pkg::nrm_t normal_x;
  vna_pkg::nrm_t normal_y;
  vna_pkg::nrm_t normal_z;
  logic          defaulted;

  modport source (output valid, vertex_index, normal_x, normal_y, normal_z, defaulted,
                  input ready);
  modport sink (input valid, vertex_index, normal_x, normal_y, normal_z, defaulted,
                output ready);
endinterface

// ===== rtl/vertex_normal_accumulate.sv =====
// Area-weighted smooth vertex normals.
// in_i takes one item per command: mode 0 loads a vertex position and zeroes
// its normal sum, mode 1 adds a triangle's face normal to its three corners,
// mode 2 reads one vertex and returns its unit normal on out_o (Q1.14).
// Modes 0 and 1 give no output item; mode 3 and out-of-range indices are
// dropped, except that mode 2 then returns (0,1,0) with defaulted set.
// Items are handled one at a time; in_i.ready is high only when idle.
// Mode 1 reads three positions, forms six products on one shared 33x33
// multiplier and, unless the face is degenerate, makes three accumulator
// RMW passes; mode 2, unless degenerate, runs a one-bit-per-cycle
// normalising shift (0 to 29 steps), a 32-step square root and three
// 16-step dividers.
// After reset the accumulator memory is zeroed, one entry per cycle, over all
// MAX_VERTICES entries; in_i.ready stays low until that pass ends. The APB
// threshold register is writable throughout and resets to 281.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already accepted, and only a second result waits
// for the first to be taken.
module vertex_normal_accumulate #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vna_in_if.sink                       in_i,
  vna_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vna_pkg::PADDR_W-1:0]  paddr,
  input  logic [vna_pkg::THR_W-1:0]    pwdata,
  output logic [vna_pkg::THR_W-1:0]    prdata,
  output logic                         pready
);
  import vna_pkg::*;

  localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PROW_W = 3 * POS_W;
  localparam int AROW_W = 3 * ACC_W;

  typedef enum logic [20:0] {
    S_CLR   = 21'h000001,
    S_IDLE  = 21'h000002,
    S_LOAD  = 21'h000004,
    S_TRA   = 21'h000008,
    S_TRB   = 21'h000010,
    S_TRC   = 21'h000020,
    S_EDGE  = 21'h000040,
    S_CROSS = 21'h000080,
    S_MAG   = 21'h000100,
    S_SQ    = 21'h000200,
    S_CHK   = 21'h000400,
    S_ACCR  = 21'h000800,
    S_ACCW  = 21'h001000,
    S_RRD   = 21'h002000,
    S_RCAP  = 21'h004000,
    S_SHIFT = 21'h008000,
    S_ISQ   = 21'h010000,
    S_DIVI  = 21'h020000,
    S_DIV   = 21'h040000,
    S_DIVO  = 21'h080000,
    S_OUT   = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic out_valid_q, out_valid_d;
  logic [THR_W-1:0] thr_q;

  logic [PROW_W-1:0] pos_mem [MAX_VERTICES];
  logic [AROW_W-1:0] acc_mem [MAX_VERTICES];
  logic [PROW_W-1:0] pos_rd_q;
  logic [AROW_W-1:0] acc_rd_q;
  logic [AW-1:0] pos_raddr, acc_raddr, acc_waddr;
  logic acc_we;
  logic [AROW_W-1:0] acc_wdata;

  mode_t mode_q;
  idx_t ia_q, ib_q, ic_q;
  pos_t px_q, py_q, pz_q;
  logic pass2_q;
  logic [1:0] corner_q, comp_q;
  logic [4:0] cnt_q;

  logic [PROW_W-1:0] pa_q, pb_q;
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic signed [ACC_W-1:0] c_q [3];
  logic [ACC_W-1:0] m_q [3];

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_q;
  logic [THR_W-1:0] sum_q;
  logic sat_q;
  logic [THR_W:0] sq_add;
  logic [THR_W-1:0] sq_val;
  logic deg;
  logic [2:0] pj;

  logic any_hi, any_top;

  logic [THR_W-1:0] v_q, res_q, bit_q, isq_t;
  logic [31:0] r_now, r_q, rem_q;
  logic [44:0] num;
  logic [NRM_W-1:0] nlo_q, q_q, qc;
  logic [32:0] dt;
  logic dge;

  nrm_t nrm_q [3];
  logic def_q;
  idx_t out_idx_q;
  nrm_t out_x_q, out_y_q, out_z_q;
  logic out_def_q;

  logic in_fire, a_ok, abc_ok;

  function automatic logic signed [EDGE_W-1:0] sx(input logic [POS_W-1:0] v);
    return $signed({v[POS_W-1], v});
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign a_ok   = 32'(in_i.vertex_a) < 32'(MAX_VERTICES);
  assign abc_ok = a_ok && (32'(in_i.vertex_b) < 32'(MAX_VERTICES))
                       && (32'(in_i.vertex_c) < 32'(MAX_VERTICES));

  assign out_o.valid        = out_valid_q;
  assign out_o.vertex_index = out_idx_q;
  assign out_o.normal_x     = out_x_q;
  assign out_o.normal_y     = out_y_q;
  assign out_o.normal_z     = out_z_q;
  assign out_o.defaulted    = out_def_q;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_THRESHOLD) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1] == REG_THRESHOLD) begin
      thr_q <= pwdata;
    end
  end

  // memories
  always_comb begin
    unique case (state_q)
      S_TRA:   pos_raddr = AW'(ia_q);
      S_TRB:   pos_raddr = AW'(ib_q);
      S_TRC:   pos_raddr = AW'(ic_q);
      default: pos_raddr = AW'(ia_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      pos_mem[AW'(ia_q)] <= {px_q, py_q, pz_q};
    end
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_comb begin
    logic [ACC_W:0] s;
    logic [ACC_W-1:0] a;
    s = '0;
    a = '0;
    acc_raddr = AW'(ia_q);
    if (state_q == S_ACCR) begin
      case (corner_q)
        2'd0:    acc_raddr = AW'(ia_q);
        2'd1:    acc_raddr = AW'(ib_q);
        default: acc_raddr = AW'(ic_q);
      endcase
    end
    acc_we    = 1'b0;
    acc_waddr = AW'(ia_q);
    acc_wdata = '0;
    unique case (state_q)
      S_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_q;
      end
      S_LOAD: acc_we = 1'b1;
      S_ACCW: begin
        acc_we = 1'b1;
        case (corner_q)
          2'd0:    acc_waddr = AW'(ia_q);
          2'd1:    acc_waddr = AW'(ib_q);
          default: acc_waddr = AW'(ic_q);
        endcase
        for (int k = 0; k < 3; k++) begin
          a = acc_rd_q[(2-k)*ACC_W +: ACC_W];
          s = {a[ACC_W-1], a} + {c_q[k][ACC_W-1], c_q[k]};
          if (s[ACC_W] != s[ACC_W-1]) begin
            acc_wdata[(2-k)*ACC_W +: ACC_W] = s[ACC_W] ? ACC_MIN : ACC_MAX;
          end else begin
            acc_wdata[(2-k)*ACC_W +: ACC_W] = s[ACC_W-1:0];
          end
        end
      end
      default: acc_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd_q <= acc_mem[acc_raddr];
  end

  // shared multiplier
  assign pj = cnt_q[2:0] - 3'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_CROSS) begin
      case (cnt_q[2:0])
        3'd0: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
        3'd1: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
        3'd2: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
        3'd3: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
        3'd4: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
        3'd5: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_SQ && cnt_q < 5'd3) begin
      mul_a = $signed({1'b0, m_q[cnt_q[1:0]][31:0]});
      mul_b = $signed({1'b0, m_q[cnt_q[1:0]][31:0]});
    end
  end

  assign sq_add = {1'b0, sum_q} + {1'b0, prod_q[THR_W-1:0]};
  assign sq_val = sat_q ? '1 : sum_q;
  assign deg    = sq_val <= thr_q;

  always_comb begin
    any_hi  = 1'b0;
    any_top = 1'b0;
    for (int k = 0; k < 3; k++) begin
      any_hi  = any_hi | (|m_q[k][ACC_W-1:30]);
      any_top = any_top | m_q[k][29];
    end
  end

  assign isq_t = res_q + bit_q;
  assign r_now = (res_q == '0) ? 32'd1 : res_q[31:0];
  assign num   = {1'b0, m_q[comp_q][29:0], 14'b0} + 45'(r_now[31:1]);
  assign dt    = {rem_q, nlo_q[NRM_W-1]};
  assign dge   = dt >= {1'b0, r_q};
  assign qc    = (q_q > ONE_Q14) ? ONE_Q14 : q_q;

  // control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_VERTICES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.mode)
            MODE_LOAD: state_d = a_ok ? S_LOAD : S_IDLE;
            MODE_TRI:  state_d = abc_ok ? S_TRA : S_IDLE;
            MODE_READ: state_d = a_ok ? S_RRD : S_OUT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD:  state_d = S_IDLE;
      S_TRA:   state_d = S_TRB;
      S_TRB:   state_d = S_TRC;
      S_TRC:   state_d = S_EDGE;
      S_EDGE:  state_d = S_CROSS;
      S_CROSS: if (cnt_q == 5'd6) state_d = S_MAG;
      S_MAG:   state_d = S_SQ;
      S_SQ:    if (cnt_q == 5'd3) state_d = S_CHK;
      S_CHK: begin
        if (pass2_q) begin
          state_d = S_ISQ;
        end else if (mode_q == MODE_TRI) begin
          state_d = deg ? S_IDLE : S_ACCR;
        end else begin
          state_d = deg ? S_OUT : S_SHIFT;
        end
      end
      S_ACCR:  state_d = S_ACCW;
      S_ACCW:  state_d = (corner_q == 2'd2) ? S_IDLE : S_ACCR;
      S_RRD:   state_d = S_RCAP;
      S_RCAP:  state_d = S_MAG;
      S_SHIFT: if (!any_hi && any_top) state_d = S_SQ;
      S_ISQ:   if (cnt_q == 5'd31) state_d = S_DIVI;
      S_DIVI:  state_d = S_DIV;
      S_DIV:   if (cnt_q == 5'd15) state_d = S_DIVO;
      S_DIVO:  state_d = (comp_q == 2'd2) ? S_OUT : S_DIVI;
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_q  <= in_i.mode;
          ia_q    <= in_i.vertex_a;
          ib_q    <= in_i.vertex_b;
          ic_q    <= in_i.vertex_c;
          px_q    <= in_i.pos_x;
          py_q    <= in_i.pos_y;
          pz_q    <= in_i.pos_z;
          pass2_q <= 1'b0;
          if (!a_ok) begin
            nrm_q[0] <= '0;
            nrm_q[1] <= $signed(ONE_Q14);
            nrm_q[2] <= '0;
            def_q    <= 1'b1;
          end
        end
      end
      S_TRB: pa_q <= pos_rd_q;
      S_TRC: pb_q <= pos_rd_q;
      S_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= sx(pb_q[(2-k)*POS_W +: POS_W]) - sx(pa_q[(2-k)*POS_W +: POS_W]);
          e2_q[k] <= sx(pos_rd_q[(2-k)*POS_W +: POS_W]) - sx(pa_q[(2-k)*POS_W +: POS_W]);
          c_q[k]  <= '0;
        end
        cnt_q <= '0;
      end
      S_CROSS: begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q != 5'd0) begin
          if (pj[0]) begin
            c_q[pj[2:1]] <= c_q[pj[2:1]] - ACC_W'($signed(prod_q[51:0]));
          end else begin
            c_q[pj[2:1]] <= c_q[pj[2:1]] + ACC_W'($signed(prod_q[51:0]));
          end
        end
      end
      S_RCAP: begin
        for (int k = 0; k < 3; k++) begin
          c_q[k] <= $signed(acc_rd_q[(2-k)*ACC_W +: ACC_W]);
        end
      end
      S_MAG: begin
        for (int k = 0; k < 3; k++) begin
          m_q[k] <= c_q[k][ACC_W-1] ? ACC_W'(-c_q[k]) : ACC_W'(c_q[k]);
        end
        sum_q <= '0;
        sat_q <= 1'b0;
        cnt_q <= '0;
      end
      S_SQ: begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q != 5'd0) begin
          sum_q <= sq_add[THR_W-1:0];
        end
        if ((cnt_q < 5'd3 && |m_q[cnt_q[1:0]][ACC_W-1:32])
            || (cnt_q != 5'd0 && sq_add[THR_W])) begin
          sat_q <= 1'b1;
        end
      end
      S_CHK: begin
        corner_q <= 2'd0;
        v_q      <= sum_q;
        res_q    <= '0;
        bit_q    <= 64'h4000_0000_0000_0000;
        cnt_q    <= '0;
        if (!pass2_q && mode_q == MODE_READ && deg) begin
          nrm_q[0] <= '0;
          nrm_q[1] <= $signed(ONE_Q14);
          nrm_q[2] <= '0;
          def_q    <= 1'b1;
        end
      end
      S_ACCW: corner_q <= corner_q + 2'd1;
      S_SHIFT: begin
        for (int k = 0; k < 3; k++) begin
          if (any_hi) begin
            m_q[k] <= m_q[k] >> 1;
          end else if (!any_top) begin
            m_q[k] <= m_q[k] << 1;
          end
        end
        if (!any_hi && any_top) begin
          pass2_q <= 1'b1;
          sum_q   <= '0;
          sat_q   <= 1'b0;
          cnt_q   <= '0;
        end
      end
      S_ISQ: begin
        cnt_q <= cnt_q + 5'd1;
        bit_q <= bit_q >> 2;
        if (v_q >= isq_t) begin
          v_q   <= v_q - isq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        comp_q <= 2'd0;
      end
      S_DIVI: begin
        r_q   <= r_now;
        rem_q <= 32'(num[44:16]);
        nlo_q <= num[15:0];
        q_q   <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        nlo_q <= nlo_q << 1;
        if (dge) begin
          rem_q <= 32'(dt - {1'b0, r_q});
          q_q   <= {q_q[NRM_W-2:0], 1'b1};
        end else begin
          rem_q <= dt[31:0];
          q_q   <= {q_q[NRM_W-2:0], 1'b0};
        end
      end
      S_DIVO: begin
        nrm_q[comp_q] <= c_q[comp_q][ACC_W-1] ? $signed(-qc) : $signed(qc);
        comp_q        <= comp_q + 2'd1;
        def_q         <= 1'b0;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_idx_q <= ia_q;
          out_x_q   <= nrm_q[0];
          out_y_q   <= nrm_q[1];
          out_z_q   <= nrm_q[2];
          out_def_q <= def_q;
        end
      end
      default: begin
      end
    endcase
  end

  a_default_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.defaulted) |->
      (out_o.normal_x == '0 && out_o.normal_y == $signed(ONE_Q14) && out_o.normal_z == '0))
    else $error("defaulted item without (0,1,0)");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < r_q))
    else $error("divider remainder not below divisor");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

endmodule

// ===== verif/vertex_normal_accumulate_tb.sv =====
`timescale 1ns / 1ps

module vertex_normal_accumulate_tb;
  import vna_pkg::*;

  localparam int NVERT     = 1024;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 300;
  localparam mode_t MODE_RSVD = 2'd3;

  typedef struct packed {
    idx_t        vertex_index;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic        defaulted;
  } normal_t;

  typedef struct {
    mode_t   mode;
    idx_t    a;
    idx_t    b;
    idx_t    c;
    pos_t    px;
    pos_t    py;
    pos_t    pz;
    logic    fixed;
    normal_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [THR_W-1:0]   pwdata, prdata;
  logic pready;

  vna_in_if  in_if ();
  vna_out_if out_if ();

  vertex_normal_accumulate dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic signed [31:0] pos_mem [NVERT][3];
  logic               pos_written [NVERT];
  logic signed [63:0] acc_mem [NVERT][3];
  logic [63:0]        thresh;

  normal_t normals_due[$];
  int  errors;
  int  idle_cycles;
  bit  timed_out;
  bit  draining;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] sq_len(input logic signed [63:0] x,
                                         input logic signed [63:0] y,
                                         input logic signed [63:0] z);
    logic [63:0] m, sum;
    logic [64:0] t;
    logic signed [63:0] cc [3];
    sum = 0;
    cc[0] = x; cc[1] = y; cc[2] = z;
    for (int i = 0; i < 3; i++) begin
      m = mag(cc[i]);
      if (m >= 64'h1_0000_0000) return '1;
      t = {1'b0, sum} + {1'b0, m * m};
      if (t[64]) return '1;
      sum = t[63:0];
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] sat56(input logic signed [63:0] a,
                                               input logic signed [63:0] d);
    logic signed [63:0] s;
    s = a + d;
    if (s > 64'sd36028797018963967) return 64'sd36028797018963967;
    if (s < -64'sd36028797018963968) return -64'sd36028797018963968;
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(input idx_t v);
    normal_t n;
    logic signed [63:0] cc [3];
    logic [63:0] m [3];
    logic [63:0] mx, s, r, q;
    int len;
    n.vertex_index = v;
    n.normal_x = 16'd0;
    n.normal_y = ONE_Q14;
    n.normal_z = 16'd0;
    n.defaulted = 1'b1;
    for (int i = 0; i < 3; i++) cc[i] = acc_mem[v][i];
    if (sq_len(cc[0], cc[1], cc[2]) <= thresh) return n;
    for (int i = 0; i < 3; i++) m[i] = mag(cc[i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    len = 0;
    while (len < 64 && (mx >> len) != 0) len++;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) m[i] = m[i] >> (len - 30);
      else if (len < 30) m[i] = m[i] << (30 - len);
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = int_sqrt(s);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (r >> 1)) / r;
      if (q > 64'd16384) q = 64'd16384;
      if (cc[i] < 0) q = -q;
      if (i == 0) n.normal_x = q[15:0];
      else if (i == 1) n.normal_y = q[15:0];
      else n.normal_z = q[15:0];
    end
    n.defaulted = 1'b0;
    return n;
  endfunction

  task automatic predict(input row_t r);
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] nv [3];
    idx_t corner [3];
    normal_t n;
    case (r.mode)
      MODE_LOAD: begin
        pos_mem[r.a][0] = r.px;
        pos_mem[r.a][1] = r.py;
        pos_mem[r.a][2] = r.pz;
        pos_written[r.a] = 1'b1;
        for (int i = 0; i < 3; i++) acc_mem[r.a][i] = 0;
      end
      MODE_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = 64'(pos_mem[r.b][i]) - 64'(pos_mem[r.a][i]);
          e2[i] = 64'(pos_mem[r.c][i]) - 64'(pos_mem[r.a][i]);
        end
        nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
        if (sq_len(nv[0], nv[1], nv[2]) > thresh) begin
          corner[0] = r.a; corner[1] = r.b; corner[2] = r.c;
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
              acc_mem[corner[k]][i] = sat56(acc_mem[corner[k]][i], nv[i]);
        end
      end
      MODE_READ: begin
        n = unit_normal(r.a);
        if (r.fixed && n !== r.want) begin
          $error("directed row: table %h vs predictor %h", r.want, n);
          errors++;
        end
        normals_due = {normals_due, n};
      end
      default: ;
    endcase
  endtask

  task automatic send(input row_t r);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= r.mode;
    in_if.vertex_a <= r.a;
    in_if.vertex_b <= r.b;
    in_if.vertex_c <= r.c;
    in_if.pos_x    <= r.px;
    in_if.pos_y    <= r.py;
    in_if.pos_z    <= r.pz;
    do @(posedge clk_i); while (!in_if.ready);
    predict(r);
  endtask

  task automatic write_threshold(input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_THRESHOLD, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thresh = v;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    wait (normals_due.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic row_t mk(input mode_t md, input idx_t a, input idx_t b,
                              input idx_t c, input pos_t x, input pos_t y,
                              input pos_t z);
    row_t r;
    r.mode = md; r.a = a; r.b = b; r.c = c;
    r.px = x; r.py = y; r.pz = z;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_read(input idx_t a, input logic fx, input normal_t w);
    row_t r;
    r = mk(MODE_READ, a, '0, '0, '0, '0, '0);
    r.fixed = fx;
    r.want = w;
    return r;
  endfunction

  function automatic idx_t pick_written();
    idx_t v;
    do v = idx_t'($urandom_range(0, 63)); while (!pos_written[v]);
    return v;
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(0, 3))
      0: return pos_t'($urandom);
      1: return pos_t'($signed($urandom_range(0, 8192)) - 4096);
      2: return $urandom_range(0, 1) ? pos_t'(24'h7fffff) : pos_t'(24'h800000);
      default: return pos_t'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // result side: random stall per item, checking
  initial begin
    normal_t got, w;
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.vertex_index = out_if.vertex_index;
      got.normal_x = out_if.normal_x;
      got.normal_y = out_if.normal_y;
      got.normal_z = out_if.normal_z;
      got.defaulted = out_if.defaulted;
      if (normals_due.size() == 0) begin
        $error("unexpected normal item for vertex %0d", got.vertex_index);
        errors++;
      end else begin
        w = normals_due.pop_front();
        if (got.vertex_index !== w.vertex_index) begin
          $error("vertex_index: expected %0d got %0d", w.vertex_index, got.vertex_index);
          errors++;
        end
        if (got.normal_x !== w.normal_x) begin
          $error("normal_x: expected %h got %h", w.normal_x, got.normal_x);
          errors++;
        end
        if (got.normal_y !== w.normal_y) begin
          $error("normal_y: expected %h got %h", w.normal_y, got.normal_y);
          errors++;
        end
        if (got.normal_z !== w.normal_z) begin
          $error("normal_z: expected %h got %h", w.normal_z, got.normal_z);
          errors++;
        end
        if (got.defaulted !== w.defaulted) begin
          $error("defaulted: expected %b got %b", w.defaulted, got.defaulted);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted items; reset clearing pass is covered by the limit
  always @(posedge clk_i) begin
    if (!rst_ni || draining || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    normal_t dflt;
    idx_t va, vb, vc;
    int n;
    errors = 0;
    draining = 1'b0;
    thresh = THR_RESET;
    for (int i = 0; i < NVERT; i++) begin
      pos_written[i] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        pos_mem[i][k] = 0;
        acc_mem[i][k] = 0;
      end
    end
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.mode = MODE_LOAD;
    in_if.vertex_a = '0; in_if.vertex_b = '0; in_if.vertex_c = '0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dflt.normal_x = 16'd0; dflt.normal_y = ONE_Q14; dflt.normal_z = 16'd0;
    dflt.defaulted = 1'b1;
    // directed: reset state, extremes, degenerate and special cases
    dflt.vertex_index = 10'd0;    dir = {dir, mk_read(10'd0, 1'b1, dflt)};
    dflt.vertex_index = 10'd1023; dir = {dir, mk_read(10'd1023, 1'b1, dflt)};
    dir = {dir, mk(MODE_LOAD, 10'd0, 10'd0, 10'd0, '0, '0, '0)};
    dir = {dir, mk(MODE_LOAD, 10'd1, 10'd0, 10'd0, 24'sd4096, '0, '0)};
    dir = {dir, mk(MODE_LOAD, 10'd2, 10'd0, 10'd0, '0, 24'sd4096, '0)};
    dir = {dir, mk(MODE_TRI, 10'd0, 10'd1, 10'd2, '0, '0, '0)};
    dir = {dir, mk_read(10'd0, 1'b0, dflt)};
    dir = {dir, mk(MODE_TRI, 10'd0, 10'd0, 10'd1, '0, '0, '0)};
    dir = {dir, mk(MODE_LOAD, 10'd1023, 10'd0, 10'd0,
                   24'sh7fffff, 24'sh800000, 24'sh7fffff)};
    dir = {dir, mk(MODE_LOAD, 10'd1022, 10'd1023, 10'd1023,
                   24'sh800000, 24'sh7fffff, 24'sh800000)};
    dir = {dir, mk(MODE_LOAD, 10'd1021, 10'd1023, 10'd1023,
                   24'sh800000, 24'sh800000, 24'sh7fffff)};
    for (int i = 0; i < 4; i++)
      dir = {dir, mk(MODE_TRI, 10'd1023, 10'd1022, 10'd1021, '0, '0, '0)};
    dir = {dir, mk_read(10'd1023, 1'b0, dflt)};
    dir = {dir, mk_read(10'd1021, 1'b0, dflt)};
    dir = {dir, mk(MODE_RSVD, 10'h3ff, 10'h3ff, 10'h3ff, 24'sh7fffff, '1, '1)};
    dir = {dir, mk(MODE_LOAD, 10'd2, 10'd0, 10'd0, 24'sd1, 24'sd1, 24'sd1)};
    dflt.vertex_index = 10'd2; dir = {dir, mk_read(10'd2, 1'b1, dflt)};
    dir = {dir, mk_read(10'd1, 1'b0, dflt)};
    foreach (dir[i]) send(dir[i]);
    settle();

    // random phases over several thresholds, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_threshold(64'd0);
        1: write_threshold(THR_RESET);
        2: write_threshold(64'd1 << 40);
        3: write_threshold({$urandom, $urandom});
        default: write_threshold('1);
      endcase
      for (int i = 0; i < 16; i++)
        send(mk(MODE_LOAD, idx_t'(i), '0, '0, rand_pos(), rand_pos(), rand_pos()));
      n = 0;
      while (n < 90) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            va = idx_t'($urandom_range(0, 63));
            r = mk(MODE_LOAD, va, idx_t'($urandom), idx_t'($urandom),
                   rand_pos(), rand_pos(), rand_pos());
          end
          2, 3, 4, 5: begin
            va = pick_written(); vb = pick_written(); vc = pick_written();
            r = mk(MODE_TRI, va, vb, vc, pos_t'($urandom), pos_t'($urandom),
                   pos_t'($urandom));
          end
          6, 7, 8: begin
            va = $urandom_range(0, 7) == 0 ? idx_t'($urandom) : pick_written();
            r = mk(MODE_READ, va, idx_t'($urandom), idx_t'($urandom),
                   pos_t'($urandom), pos_t'($urandom), pos_t'($urandom));
          end
          default: begin
            r = mk(MODE_RSVD, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
                   pos_t'($urandom), pos_t'($urandom), pos_t'($urandom));
          end
        endcase
        send(r);
        n++;
        if (ph == 2 && n == 50) begin
          in_if.valid <= 1'b0;
          wait (normals_due.size() == 0);
          @(posedge clk_i);
        end
      end
      settle();
    end

    draining = 1'b1;
    fork
      wait (normals_due.size() == 0);
      begin
        repeat (WDOG_MAX) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any
    if (timed_out) begin
      $display("RESULT: ERROR");
      $finish;
    end
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== vertex_normal_accumulate.f =====
rtl/vna_pkg.sv
rtl/vna_in_if.sv
rtl/vna_out_if.sv
rtl/vertex_normal_accumulate.sv
verif/vertex_normal_accumulate_tb.sv
